// ===== rtl/ffba_pkg.sv =====
package ffba_pkg;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned CfgDataW = 11;
  localparam int unsigned ReqW     = 10;
  localparam int unsigned AddrW    = 10;
  localparam int unsigned StatusW  = 2;

  localparam logic [CfgDataW-1:0] ArenaReset = 11'd1024;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [StatusW-1:0] ST_OK       = 2'd0;
  localparam logic [StatusW-1:0] ST_NO_FIT   = 2'd1;
  localparam logic [StatusW-1:0] ST_BAD_FREE = 2'd2;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_DECODE,
    S_A_RD,
    S_A_CHK,
    S_A_SPLIT,
    S_F_START,
    S_F_H,
    S_F_NXRD,
    S_F_NX,
    S_F_PRD,
    S_F_P,
    S_F_DROP,
    S_RESP
  } ffba_state_t;

  typedef enum logic [4:0] {
    ACT_NONE,
    ACT_CLR,
    ACT_LOAD,
    ACT_RD_CUR,
    ACT_ADV,
    ACT_SPLIT1,
    ACT_SPLIT2,
    ACT_TAKE,
    ACT_NOFIT,
    ACT_BAD,
    ACT_RD_H,
    ACT_LATCH_H,
    ACT_RD_NX,
    ACT_MERGE_NX,
    ACT_RD_P,
    ACT_KEEP_H,
    ACT_MERGE_P,
    ACT_DROP_H,
    ACT_PUSH
  } ffba_act_t;

  typedef struct packed {
    logic clr_last;
    logic op_free;
    logic cur_end;
    logic rd_valid;
    logic rd_free;
    logic fit;
    logic split;
    logic addr_bad;
    logic hnx_in;
    logic p_ok;
    logic out_free;
  } ffba_status_t;

endpackage

// ===== rtl/ffba_ctrl.sv =====
module ffba_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  ffba_pkg::ffba_status_t status,
  output ffba_pkg::ffba_act_t   act
);
  import ffba_pkg::*;

  ffba_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:     if (status.clr_last) state_nxt = S_IDLE;
      S_IDLE:    if (in_tvalid) state_nxt = S_DECODE;
      S_DECODE:  state_nxt = status.op_free ? S_F_START : S_A_RD;
      S_A_RD:    state_nxt = status.cur_end ? S_RESP : S_A_CHK;
      S_A_CHK: begin
        priority if (!status.rd_valid) state_nxt = S_RESP;
        else if (status.fit && status.split) state_nxt = S_A_SPLIT;
        else if (status.fit) state_nxt = S_RESP;
        else state_nxt = S_A_RD;
      end
      S_A_SPLIT: state_nxt = S_RESP;
      S_F_START: state_nxt = status.addr_bad ? S_RESP : S_F_H;
      S_F_H: begin
        if (!status.rd_valid || status.rd_free) state_nxt = S_RESP;
        else state_nxt = S_F_NXRD;
      end
      S_F_NXRD:  state_nxt = status.hnx_in ? S_F_NX : S_F_PRD;
      S_F_NX:    state_nxt = S_F_PRD;
      S_F_PRD:   state_nxt = status.p_ok ? S_F_P : S_RESP;
      S_F_P:     state_nxt = (status.rd_valid && status.rd_free) ? S_F_DROP : S_RESP;
      S_F_DROP:  state_nxt = S_RESP;
      S_RESP:    if (status.out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_CLR;
    endcase
    // A new arena size restarts the clearing sweep wherever we are.
    if (cfg_valid) state_nxt = S_CLR;
  end

  always_comb begin
    act       = ACT_NONE;
    in_tready = 1'b0;
    unique case (state_r)
      S_CLR: act = ACT_CLR;
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) act = ACT_LOAD;
      end
      S_DECODE: act = ACT_NONE;
      S_A_RD:   act = status.cur_end ? ACT_NOFIT : ACT_RD_CUR;
      S_A_CHK: begin
        priority if (!status.rd_valid) act = ACT_NOFIT;
        else if (status.fit && status.split) act = ACT_SPLIT1;
        else if (status.fit) act = ACT_TAKE;
        else act = ACT_ADV;
      end
      S_A_SPLIT: act = ACT_SPLIT2;
      S_F_START: act = status.addr_bad ? ACT_BAD : ACT_RD_H;
      S_F_H: begin
        if (!status.rd_valid || status.rd_free) act = ACT_BAD;
        else act = ACT_LATCH_H;
      end
      S_F_NXRD: act = status.hnx_in ? ACT_RD_NX : ACT_NONE;
      S_F_NX:   act = (status.rd_valid && status.rd_free) ? ACT_MERGE_NX : ACT_NONE;
      S_F_PRD:  act = status.p_ok ? ACT_RD_P : ACT_KEEP_H;
      S_F_P:    act = (status.rd_valid && status.rd_free) ? ACT_MERGE_P : ACT_KEEP_H;
      S_F_DROP: act = ACT_DROP_H;
      S_RESP:   act = status.out_free ? ACT_PUSH : ACT_NONE;
      default:  act = ACT_NONE;
    endcase
  end

endmodule

// ===== rtl/ffba_datapath.sv =====
module ffba_datapath #(
  parameter int unsigned ARENA_UNITS  = 1024,
  parameter int unsigned HEADER_UNITS = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [ffba_pkg::CfgDataW-1:0]     cfg_data,
  input  logic [ffba_pkg::InDataW-1:0]      in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ffba_pkg::OutDataW-1:0]     out_tdata,
  input  ffba_pkg::ffba_act_t               act,
  output ffba_pkg::ffba_status_t            status
);
  import ffba_pkg::*;

  localparam int unsigned IW = $clog2(ARENA_UNITS);
  localparam int unsigned SW = ((IW > ReqW) ? IW : ReqW) + 2;
  localparam int unsigned EW = IW + 2;
  localparam logic [SW-1:0] HDR      = SW'(HEADER_UNITS);
  localparam logic [SW-1:0] ARENA    = SW'(ARENA_UNITS);
  localparam logic [IW-1:0] CLR_LAST = IW'(ARENA_UNITS - 1);

  // Entry word: valid, free, payload size.
  logic [EW-1:0] info_mem [ARENA_UNITS];
  logic [IW-1:0] prev_mem [ARENA_UNITS];

  logic [CfgDataW-1:0] arena_size_r;
  logic [IW-1:0]       clr_cnt_r;
  logic                op_r;
  logic [ReqW-1:0]     req_r;
  logic [AddrW-1:0]    addr_r;
  logic [SW-1:0]       cur_r;
  logic [SW-1:0]       hsize_r;
  logic [IW-1:0]       hprev_r;
  logic [AddrW-1:0]    res_addr_r;
  logic [StatusW-1:0]  res_status_r;
  logic                out_valid_r;
  logic [AddrW-1:0]    out_addr_r;
  logic [StatusW-1:0]  out_status_r;
  logic [EW-1:0]       rd_info_r;
  logic [IW-1:0]       rd_prev_r;

  logic [SW-1:0] arena_w, rd_size, req_w, cur_nx, split_n, addr_w, h_w, hnx, second;
  logic [SW-1:0] rem_size, init_size, merged_nx, merged_p, grant_w;
  logic          rd_valid, rd_free;
  logic [IW-1:0] rd_addr;
  logic          info_we, prev_we;
  logic [IW-1:0] info_wa, prev_wa;
  logic [EW-1:0] info_wd;
  logic [IW-1:0] prev_wd;

  assign arena_w   = (SW'(arena_size_r) < ARENA) ? SW'(arena_size_r) : ARENA;
  assign rd_valid  = rd_info_r[EW-1];
  assign rd_free   = rd_info_r[EW-2];
  assign rd_size   = SW'(rd_info_r[IW-1:0]);
  assign req_w     = SW'(req_r);
  assign cur_nx    = cur_r + HDR + rd_size;
  assign split_n   = cur_r + HDR + req_w;
  assign rem_size  = rd_size - req_w - HDR;
  assign addr_w    = SW'(addr_r);
  assign h_w       = addr_w - HDR;
  assign hnx       = cur_r + HDR + hsize_r;
  assign second    = hnx + HDR + rd_size;
  assign merged_nx = hsize_r + rd_size + HDR;
  assign merged_p  = rd_size + hsize_r + HDR;
  assign init_size = arena_w - HDR;
  assign grant_w   = cur_r + HDR;

  always_comb begin
    status.clr_last = (clr_cnt_r == CLR_LAST);
    status.op_free  = (op_r == OP_FREE);
    status.cur_end  = (cur_r >= arena_w);
    status.rd_valid = rd_valid;
    status.rd_free  = rd_free;
    status.fit      = rd_free && (rd_size >= req_w);
    status.split    = (rd_size > (req_w + HDR));
    status.addr_bad = (addr_w < HDR) || (h_w >= arena_w);
    status.hnx_in   = (hnx < arena_w);
    status.p_ok     = (cur_r != '0) && (SW'(hprev_r) < arena_w);
    status.out_free = !out_valid_r || out_tready;
  end

  // Read address and the two write ports, chosen by the current action.
  always_comb begin
    rd_addr = cur_r[IW-1:0];
    info_we = 1'b0;
    info_wa = cur_r[IW-1:0];
    info_wd = '0;
    prev_we = 1'b0;
    prev_wa = cur_r[IW-1:0];
    prev_wd = '0;
    unique case (act)
      ACT_CLR: begin
        info_we = 1'b1;
        info_wa = clr_cnt_r;
        if (clr_cnt_r == '0 && arena_w >= HDR) info_wd = {2'b11, init_size[IW-1:0]};
      end
      ACT_RD_CUR: rd_addr = cur_r[IW-1:0];
      ACT_SPLIT1: begin
        prev_we = (cur_nx < arena_w);
        prev_wa = cur_nx[IW-1:0];
        prev_wd = split_n[IW-1:0];
        info_we = 1'b1;
        info_wa = split_n[IW-1:0];
        info_wd = {2'b11, rem_size[IW-1:0]};
      end
      ACT_SPLIT2: begin
        prev_we = 1'b1;
        prev_wa = split_n[IW-1:0];
        prev_wd = cur_r[IW-1:0];
        info_we = 1'b1;
        info_wd = {2'b10, req_w[IW-1:0]};
      end
      ACT_TAKE: begin
        info_we = 1'b1;
        info_wd = {2'b10, rd_size[IW-1:0]};
      end
      ACT_RD_H:  rd_addr = h_w[IW-1:0];
      ACT_RD_NX: rd_addr = hnx[IW-1:0];
      ACT_MERGE_NX: begin
        info_we = 1'b1;
        info_wa = hnx[IW-1:0];
        prev_we = (second < arena_w);
        prev_wa = second[IW-1:0];
        prev_wd = cur_r[IW-1:0];
      end
      ACT_RD_P: rd_addr = hprev_r;
      ACT_KEEP_H: begin
        info_we = 1'b1;
        info_wd = {2'b11, hsize_r[IW-1:0]};
      end
      ACT_MERGE_P: begin
        info_we = 1'b1;
        info_wa = hprev_r;
        info_wd = {2'b11, merged_p[IW-1:0]};
        prev_we = (hnx < arena_w);
        prev_wa = hnx[IW-1:0];
        prev_wd = hprev_r;
      end
      ACT_DROP_H: info_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (info_we) info_mem[info_wa] <= info_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    rd_info_r <= info_mem[rd_addr];
    rd_prev_r <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arena_size_r <= ArenaReset;
      clr_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        arena_size_r <= cfg_data;
        clr_cnt_r    <= '0;
      end else if (act == ACT_CLR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (act == ACT_PUSH) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (act)
      ACT_LOAD: begin
        op_r   <= in_tdata[0];
        req_r  <= in_tdata[ReqW:1];
        addr_r <= in_tdata[ReqW+AddrW:ReqW+1];
        cur_r  <= '0;
      end
      ACT_ADV:  cur_r <= cur_nx;
      ACT_RD_H: cur_r <= h_w;
      ACT_LATCH_H: begin
        hsize_r <= rd_size;
        hprev_r <= rd_prev_r;
      end
      ACT_MERGE_NX: hsize_r <= merged_nx;
      ACT_SPLIT2, ACT_TAKE: begin
        res_addr_r   <= grant_w[AddrW-1:0];
        res_status_r <= ST_OK;
      end
      ACT_NOFIT: begin
        res_addr_r   <= '0;
        res_status_r <= ST_NO_FIT;
      end
      ACT_BAD: begin
        res_addr_r   <= '0;
        res_status_r <= ST_BAD_FREE;
      end
      ACT_KEEP_H, ACT_DROP_H: begin
        res_addr_r   <= '0;
        res_status_r <= ST_OK;
      end
      ACT_PUSH: begin
        out_addr_r   <= res_addr_r;
        out_status_r <= res_status_r;
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW - AddrW - StatusW){1'b0}}, out_status_r, out_addr_r};

endmodule

// ===== rtl/first_fit_block_allocator.sv =====
// Channel  Ports                           Beat contents
// in       in_tvalid/in_tready/in_tdata    op, request_size, block_address
// out      out_tvalid/out_tready/out_tdata payload_address, status
// cfg      cfg_valid/cfg_ready/cfg_data    arena_size
//
// An allocate walks the header chain from the arena start; each block visited is one
// header read and one check, and splitting a block adds a second header write step.
// A free proceeds one header read or write at a time.
// After reset and each arena_size write, a sweep clears all ARENA_UNITS headers.
// A result waits in the output register while the next beat is taken; the result
// after it holds the block until that register drains.
module first_fit_block_allocator #(
  parameter int unsigned ARENA_UNITS  = 1024,
  parameter int unsigned HEADER_UNITS = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // op [0], request_size [10:1], block_address [20:11]
  input  logic [ffba_pkg::InDataW-1:0]  in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // payload_address [9:0], status [11:10]
  output logic [ffba_pkg::OutDataW-1:0] out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ffba_pkg::CfgDataW-1:0] cfg_data
);
  import ffba_pkg::*;

  ffba_act_t    act;
  ffba_status_t status;

  assign cfg_ready = 1'b1;

  ffba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .act       (act)
  );

  ffba_datapath #(
    .ARENA_UNITS  (ARENA_UNITS),
    .HEADER_UNITS (HEADER_UNITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .act        (act),
    .status     (status)
  );

endmodule

// ===== rtl/ffba_checker.sv =====
module ffba_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [ffba_pkg::OutDataW-1:0] out_tdata,
  input logic                          cfg_valid
);
  import ffba_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[11:10] == ST_OK || out_tdata[11:10] == ST_NO_FIT ||
                    out_tdata[11:10] == ST_BAD_FREE))
    else $error("undefined status code");

  a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[11:10] != ST_OK |-> out_tdata[9:0] == '0)
    else $error("failed request carries an address");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second beat taken while busy");

  a_cfg_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |=> !in_tready)
    else $error("beat taken during clearing sweep");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_valid  (cfg_valid)
);
